// File: sv/battery_level_median_hysteresis_unit_defines.svh
// Assertion macros shared by the battery level block.
// Each expects clk and rst to be visible where it is used.
`ifndef BATTERY_LEVEL_MEDIAN_HYSTERESIS_UNIT_DEFINES_SVH
`define BATTERY_LEVEL_MEDIAN_HYSTERESIS_UNIT_DEFINES_SVH

// Same-cycle implication, held off during reset
`define BLMH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset
`define BLMH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/blmh_pkg.sv
package blmh_pkg;

  // Word and field widths
  localparam int ADC_W    = 16;
  localparam int PCT_W    = 7;
  localparam int CHAN_W   = 4;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  // Scaling datapath widths
  localparam int MULK_W   = 11;
  localparam int X_W      = 27;
  localparam int D_W      = 20;
  localparam int REM_W    = 27;
  localparam int DIV_W    = 20;

  // Shared multiplier operand and product widths
  localparam int MUL_AW   = 27;
  localparam int MUL_BW   = 20;
  localparam int MUL_PW   = 47;

  // Reciprocal shift: 2^27 exceeds every slope product, so the estimate is
  // at most one below the true quotient
  localparam int RECIP_SH = 27;

  // Register index decoded from paddr[2]
  localparam logic REG_ADC_CHANNEL = 1'b0;

  // Channel that carries the battery divider
  localparam logic [CHAN_W-1:0] BATT_CHANNEL = 4'd8;

  // Voltage scaling: 10*v*den = code*mult, percent = 167*(x-lo)/(10*den)
  localparam logic [MULK_W-1:0] BATT_MULT  = 11'd360;
  localparam logic [MULK_W-1:0] GPIO_MULT  = 11'd1750;
  localparam logic [X_W-1:0]    BATT_LO    = 27'd120750;
  localparam logic [X_W-1:0]    BATT_HI    = 27'd149730;
  localparam logic [X_W-1:0]    GPIO_LO    = 27'd2560000;
  localparam logic [X_W-1:0]    GPIO_HI    = 27'd3174400;
  localparam logic [DIV_W-1:0]  BATT_DIV   = 20'd48300;
  localparam logic [DIV_W-1:0]  GPIO_DIV   = 20'd1024000;
  localparam logic [DIV_W-1:0]  BATT_RECIP = 20'd2778;
  localparam logic [DIV_W-1:0]  GPIO_RECIP = 20'd131;
  localparam logic [7:0]        SLOPE      = 8'd167;

  // Level limits and hysteresis thresholds
  localparam logic [PCT_W-1:0] PCT_MAX    = 7'd100;
  localparam logic [PCT_W-1:0] PCT_FLOOR  = 7'd10;
  localparam logic [7:0]       RISE_STEP  = 8'd20;
  localparam logic [7:0]       FALL_STEP  = 8'd10;
  localparam logic [7:0]       FALL_SMALL = 8'd5;
  localparam logic [1:0]       RISE_HITS  = 2'd2;
  localparam logic [1:0]       FALL_HITS  = 2'd3;

  // Main sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_RANK,
    ST_HYST,
    ST_FINISH
  } blmh_state_t;

  // Scaling unit sequencer
  typedef enum logic [2:0] {
    SC_IDLE,
    SC_CLAMP,
    SC_PROD,
    SC_DIV,
    SC_FIX,
    SC_FIN
  } scale_state_t;

  // Result of the scaling unit
  typedef struct packed {
    logic             done;
    logic [PCT_W-1:0] pct;
  } scale_res_t;

endpackage

// File: sv/blmh_if.sv
// Sample word channel
interface blmh_in_if import blmh_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ADC_W-1:0] adc_code;

  modport source (output valid, output adc_code, input ready);
  modport sink   (input valid, input adc_code, output ready);
endinterface

// Level word channel
interface blmh_out_if import blmh_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PCT_W-1:0] level_percent;
  logic             window_done;

  modport source (output valid, output level_percent, output window_done, input ready);
  modport sink   (input valid, input level_percent, input window_done, output ready);
endinterface

// File: sv/blmh_scale.sv
module blmh_scale import blmh_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ADC_W-1:0]  code,
  input  logic [CHAN_W-1:0] channel,
  output scale_res_t        res
);

  scale_state_t       st;
  scale_state_t       st_next;
  logic               is_batt;
  logic [X_W-1:0]     x;
  logic [D_W-1:0]     d;
  logic [REM_W-1:0]   rem;
  logic [PCT_W-1:0]   quo;

  logic [MULK_W-1:0]  mult_k;
  logic [X_W-1:0]     lo;
  logic [X_W-1:0]     hi;
  logic [X_W-1:0]     x_clamp;
  logic [DIV_W-1:0]   div_k;
  logic [DIV_W-1:0]   recip;
  logic [MUL_AW-1:0]  mul_a;
  logic [MUL_BW-1:0]  mul_b;
  logic [MUL_PW-1:0]  mul_p;
  logic [REM_W-1:0]   fix_rem;
  logic               bump;

  // Scale factor of the selected channel
  assign mult_k = (channel == BATT_CHANNEL) ? BATT_MULT : GPIO_MULT;

  // Clamp window, divisor and reciprocal of the captured scaling
  assign lo      = is_batt ? BATT_LO : GPIO_LO;
  assign hi      = is_batt ? BATT_HI : GPIO_HI;
  assign x_clamp = (x < lo) ? lo : ((x > hi) ? hi : x);
  assign div_k   = is_batt ? BATT_DIV : GPIO_DIV;
  assign recip   = is_batt ? BATT_RECIP : GPIO_RECIP;

  // Shared multiplier: code product, slope product, quotient estimate, check
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (st)
      SC_IDLE: begin
        mul_a = MUL_AW'({code[ADC_W-1:1], 1'b0});
        mul_b = MUL_BW'(mult_k);
      end
      SC_PROD: begin
        mul_a = MUL_AW'(d);
        mul_b = MUL_BW'(SLOPE);
      end
      SC_DIV: begin
        mul_a = MUL_AW'(rem);
        mul_b = recip;
      end
      SC_FIX: begin
        mul_a = MUL_AW'(quo);
        mul_b = div_k;
      end
      default: begin
      end
    endcase
  end

  assign mul_p = MUL_PW'(mul_a) * MUL_PW'(mul_b);

  // Remainder left by the estimate; one more divisor fits when it is short
  assign fix_rem = rem - REM_W'(mul_p);
  assign bump    = (fix_rem >= REM_W'(div_k));

  // Next state
  always_comb begin
    st_next = st;
    unique case (st)
      SC_IDLE:  if (start) st_next = SC_CLAMP;
      SC_CLAMP: st_next = SC_PROD;
      SC_PROD:  st_next = SC_DIV;
      SC_DIV:   st_next = SC_FIX;
      SC_FIX:   st_next = SC_FIN;
      SC_FIN:   st_next = SC_IDLE;
      default:  st_next = SC_IDLE;
    endcase
  end

  // Outputs: capped quotient once the correction is in
  always_comb begin
    res.done = 1'b0;
    res.pct  = (quo > PCT_MAX) ? PCT_MAX : quo;
    unique case (st)
      SC_FIN:  res.done = 1'b1;
      default: res.done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= SC_IDLE;
    end else begin
      st <= st_next;
    end
  end

  // Datapath: product, clamp, slope product, reciprocal estimate, correction
  always_ff @(posedge clk) begin
    case (st)
      SC_IDLE: begin
        if (start) begin
          x       <= X_W'(mul_p);
          is_batt <= (channel == BATT_CHANNEL);
        end
      end
      SC_CLAMP: begin
        d <= D_W'(x_clamp - lo);
      end
      SC_PROD: begin
        rem <= REM_W'(mul_p);
      end
      SC_DIV: begin
        quo <= mul_p[RECIP_SH +: PCT_W];
      end
      SC_FIX: begin
        if (bump) begin
          quo <= quo + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: sv/battery_level_median_hysteresis_unit.sv
// Battery level estimator.
// Channel adc (sink) takes one converter word per handshake; channel level
// (source) returns one word per sample: level_percent (10..100) and
// window_done. adc_channel is set over the APB port at byte address 0 and is
// to be written only while the block is idle; the block does not enforce this.
// Each sample is scaled to a percent by one shared multiplier under a small
// sequencer: the code product, a clamp step, a slope product, a reciprocal
// estimate of the quotient and one correction step. The word that closes a
// window of WINDOW_SIZE samples then walks the window once, one candidate
// rank per cycle, to find the median, and a hysteresis step follows.
// adc.ready is high only in idle, so a new word is taken only after the
// previous result has moved on to the output register.
// The finished word waits in an output register; a stalled receiver does not
// hold back the next sample, only the hand-over of its result and later words.
// Reset clears the window fill, the stored level, the hysteresis counters,
// adc_channel and the output valid flag.
`include "battery_level_median_hysteresis_unit_defines.svh"

module battery_level_median_hysteresis_unit import blmh_pkg::*; #(
  parameter int WINDOW_SIZE = 7
) (
  input  logic              clk,
  input  logic              rst,
  blmh_in_if.sink           adc,
  blmh_out_if.source        level,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int IDX_W  = $clog2(WINDOW_SIZE);
  localparam int RANK_W = $clog2(WINDOW_SIZE + 1);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(WINDOW_SIZE - 1);
  localparam logic [RANK_W-1:0] MID_RANK = RANK_W'(WINDOW_SIZE / 2);

  blmh_state_t       st;
  blmh_state_t       st_next;
  logic [CHAN_W-1:0] adc_channel;
  logic [PCT_W-1:0]  window [WINDOW_SIZE];
  logic [IDX_W-1:0]  fill_cnt;
  logic [IDX_W-1:0]  cand;
  logic [PCT_W-1:0]  median;
  logic [PCT_W-1:0]  stored_level;
  logic [1:0]        rise_cnt;
  logic [1:0]        fall_cnt;
  logic [PCT_W-1:0]  res_level;
  logic              res_done;
  logic              out_valid;
  logic [PCT_W-1:0]  out_level;
  logic              out_done;

  logic              in_fire;
  logic              cfg_write;
  logic              out_free;
  logic              window_full;
  scale_res_t        scale_res;
  logic [PCT_W-1:0]  cand_val;
  logic [RANK_W-1:0] rank;
  logic [PCT_W-1:0]  s0;
  logic [7:0]        m8;
  logic [7:0]        s8;
  logic [1:0]        rise_inc;
  logic [1:0]        fall_inc;
  logic [PCT_W-1:0]  hyst_out;
  logic [PCT_W-1:0]  stored_next;
  logic [1:0]        rise_next;
  logic [1:0]        fall_next;
  logic [PCT_W-1:0]  level_next;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_ADC_CHANNEL);
  assign prdata    = (paddr[2] == REG_ADC_CHANNEL) ?
                     CFG_DW'(adc_channel) : '0;

  // Handshakes
  assign adc.ready   = (st == ST_IDLE);
  assign in_fire     = adc.valid && (st == ST_IDLE);
  assign out_free    = !out_valid || level.ready;
  assign window_full = (fill_cnt == LAST_IDX);

  assign level.valid         = out_valid;
  assign level.level_percent = out_level;
  assign level.window_done   = out_done;

  // Shared scaling unit
  blmh_scale u_scale (
    .clk     (clk),
    .rst     (rst),
    .start   (in_fire),
    .code    (adc.adc_code),
    .channel (adc_channel),
    .res     (scale_res)
  );

  // Rank of the current candidate; ties broken by slot order
  always_comb begin
    cand_val = window[cand];
    rank     = '0;
    for (int j = 0; j < WINDOW_SIZE; j++) begin
      if ((window[j] < cand_val) ||
          ((window[j] == cand_val) && (IDX_W'(j) < cand))) begin
        rank = rank + 1'b1;
      end
    end
  end

  // Hysteresis against the stored level
  always_comb begin
    s0          = (stored_level == '0) ? median : stored_level;
    m8          = {1'b0, median};
    s8          = {1'b0, s0};
    rise_inc    = rise_cnt + 2'd1;
    fall_inc    = fall_cnt + 2'd1;
    hyst_out    = s0;
    stored_next = s0;
    rise_next   = rise_cnt;
    fall_next   = fall_cnt;
    if (median >= s0) begin
      if (m8 >= s8 + RISE_STEP) begin
        if (rise_inc >= RISE_HITS) begin
          rise_next   = '0;
          stored_next = median;
          hyst_out    = median;
        end else begin
          rise_next = rise_inc;
        end
      end else begin
        rise_next = '0;
      end
    end else begin
      if (m8 + FALL_STEP <= s8) begin
        if (fall_inc >= FALL_HITS) begin
          fall_next   = '0;
          stored_next = median;
          hyst_out    = median;
        end else begin
          fall_next = fall_inc;
        end
      end else if (m8 + FALL_SMALL > s8) begin
        fall_next   = '0;
        stored_next = median;
        hyst_out    = median;
      end else begin
        fall_next = '0;
        hyst_out  = median;
      end
    end
  end

  // Floor the reported level
  always_comb begin
    if (st == ST_HYST) begin
      level_next = hyst_out;
    end else begin
      level_next = scale_res.pct;
    end
    if (level_next < PCT_FLOOR) begin
      level_next = PCT_FLOOR;
    end
  end

  // Next state
  always_comb begin
    st_next = st;
    unique case (st)
      ST_IDLE:   if (in_fire) st_next = ST_SCALE;
      ST_SCALE: begin
        if (scale_res.done) begin
          st_next = window_full ? ST_RANK : ST_FINISH;
        end
      end
      ST_RANK:   if (cand == LAST_IDX) st_next = ST_HYST;
      ST_HYST:   st_next = ST_FINISH;
      ST_FINISH: if (out_free) st_next = ST_IDLE;
      default:   st_next = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= ST_IDLE;
      adc_channel  <= '0;
      fill_cnt     <= '0;
      stored_level <= '0;
      rise_cnt     <= '0;
      fall_cnt     <= '0;
      out_valid    <= 1'b0;
    end else begin
      st <= st_next;
      if (cfg_write) begin
        adc_channel <= pwdata[CHAN_W-1:0];
      end
      if ((st == ST_SCALE) && scale_res.done) begin
        fill_cnt <= window_full ? '0 : fill_cnt + 1'b1;
      end
      if (st == ST_HYST) begin
        stored_level <= stored_next;
        rise_cnt     <= rise_next;
        fall_cnt     <= fall_next;
      end
      if ((st == ST_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (level.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: window slots, median search, result and output words
  always_ff @(posedge clk) begin
    case (st)
      ST_SCALE: begin
        if (scale_res.done) begin
          window[fill_cnt] <= scale_res.pct;
          res_level        <= level_next;
          res_done         <= 1'b0;
          cand             <= '0;
        end
      end
      ST_RANK: begin
        if (rank == MID_RANK) begin
          median <= cand_val;
        end
        cand <= cand + 1'b1;
      end
      ST_HYST: begin
        res_level <= level_next;
        res_done  <= 1'b1;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_level <= res_level;
          out_done  <= res_done;
        end
      end
      default: begin
      end
    endcase
  end

  `BLMH_ASSERT_NEXT(a_accept_starts_scale, in_fire, (st == ST_SCALE), "accepted word did not start scaling")
  `BLMH_ASSERT_NOW(a_scale_done_in_scale, scale_res.done, (st == ST_SCALE), "scaling finished outside the scale state")
  `BLMH_ASSERT_NOW(a_level_range, out_valid, ((out_level >= PCT_FLOOR) && (out_level <= PCT_MAX)), "reported level out of range")
  `BLMH_ASSERT_NOW(a_window_wrapped, (st == ST_HYST), (fill_cnt == '0), "window fill not wrapped at median")
  `BLMH_ASSERT_NOW(a_hits_bounded, 1'b1, ((rise_cnt < RISE_HITS) && (fall_cnt < FALL_HITS)), "hysteresis counter passed its hit count")

endmodule

// File: tb/sv/battery_level_median_hysteresis_unit_test.sv
`timescale 1ns / 1ps

module battery_level_median_hysteresis_unit_test;
  import blmh_pkg::*;

  localparam int WIN          = 7;
  localparam int MID          = WIN / 2;
  localparam int DIRECTED_N   = 24;
  localparam int RANDOM_WORDS = 1400;
  localparam int SETTLE       = 40;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int MAX_REPORTS  = 10;

  // Channel settings used by name
  localparam logic [CHAN_W-1:0] GPIO_CHAN_LOW = 4'd0;
  localparam logic [CHAN_W-1:0] GPIO_CHAN_MAX = 4'd10;
  localparam logic [CHAN_W-1:0] GPIO_CHAN_TOP = 4'd15;

  // Byte address of adc_channel
  localparam logic [CFG_AW-1:0] ADDR_ADC_CHANNEL = {REG_ADC_CHANNEL, 2'b00};

  typedef struct packed {
    logic [PCT_W-1:0] pct;
    logic             done;
  } level_word_t;

  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic [ADC_W-1:0]  code;
    logic              typed;
    logic [PCT_W-1:0]  pct;
    logic              done;
  } stim_row_t;

  // Directed words: extremes on both scalings, bit 0 ignored, unset level taken
  // by the first median, then two large falls held off against the stored level
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_N] = '{
    '{GPIO_CHAN_LOW, 16'h0000, 1'b1, 7'd10,  1'b0},
    '{GPIO_CHAN_LOW, 16'hffff, 1'b1, 7'd100, 1'b0},
    '{GPIO_CHAN_LOW, 16'h0001, 1'b1, 7'd10,  1'b0},
    '{GPIO_CHAN_LOW, 16'hfffe, 1'b1, 7'd100, 1'b0},
    '{GPIO_CHAN_LOW, 16'h06f0, 1'b0, 7'd0,   1'b0},
    '{GPIO_CHAN_LOW, 16'h06f1, 1'b0, 7'd0,   1'b0},
    '{GPIO_CHAN_LOW, 16'h06f0, 1'b0, 7'd0,   1'b0},
    '{BATT_CHANNEL,  16'h0000, 1'b1, 7'd10,  1'b0},
    '{BATT_CHANNEL,  16'hffff, 1'b1, 7'd100, 1'b0},
    '{BATT_CHANNEL,  16'h0151, 1'b0, 7'd0,   1'b0},
    '{BATT_CHANNEL,  16'h0154, 1'b0, 7'd0,   1'b0},
    '{BATT_CHANNEL,  16'h0154, 1'b0, 7'd0,   1'b0},
    '{BATT_CHANNEL,  16'h0155, 1'b0, 7'd0,   1'b0},
    '{BATT_CHANNEL,  16'h0154, 1'b0, 7'd0,   1'b0},
    '{BATT_CHANNEL,  16'h0154, 1'b0, 7'd0,   1'b0},
    '{BATT_CHANNEL,  16'h0154, 1'b0, 7'd0,   1'b0},
    '{BATT_CHANNEL,  16'h0155, 1'b0, 7'd0,   1'b0},
    '{BATT_CHANNEL,  16'h0154, 1'b0, 7'd0,   1'b0},
    '{BATT_CHANNEL,  16'h0154, 1'b0, 7'd0,   1'b0},
    '{BATT_CHANNEL,  16'h0154, 1'b0, 7'd0,   1'b0},
    '{BATT_CHANNEL,  16'h0001, 1'b0, 7'd0,   1'b0},
    '{GPIO_CHAN_TOP, 16'hffff, 1'b1, 7'd100, 1'b0},
    '{GPIO_CHAN_TOP, 16'h06f0, 1'b0, 7'd0,   1'b0},
    '{GPIO_CHAN_TOP, 16'h0600, 1'b0, 7'd0,   1'b0}
  };

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  blmh_in_if  adc_if ();
  blmh_out_if level_if ();

  battery_level_median_hysteresis_unit #(
    .WINDOW_SIZE(WIN)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .adc    (adc_if),
    .level  (level_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Predictor state
  logic [PCT_W-1:0]  window_pct [WIN];
  int                window_fill;
  int                held_level;
  int                up_hits;
  int                down_hits;
  logic [CHAN_W-1:0] chan_sel;

  level_word_t pending_levels [$];
  int          level_errors;
  int          cycle_count;
  bit          no_gaps;
  int          target_level;
  bit          noisy_window;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Scale one converter word to a percent, exact rational floor
  function automatic logic [PCT_W-1:0] percent_of(logic [ADC_W-1:0] code,
                                                  logic [CHAN_W-1:0] chan);
    longint unsigned even_code, num, den, x, lo, hi, p;
    even_code = 64'(code & 16'hfffe);
    if (chan == BATT_CHANNEL) begin
      num = even_code * 36;
      den = 4830;
    end else begin
      num = even_code * 175;
      den = 102400;
    end
    x  = num * 10;
    lo = 25 * den;
    hi = 31 * den;
    if (x < lo) x = lo;
    if (x > hi) x = hi;
    p = (167 * (x - lo)) / (10 * den);
    if (p > 100) p = 100;
    return p[PCT_W-1:0];
  endfunction

  // Middle entry of the sorted window
  function automatic int window_median();
    logic [PCT_W-1:0] sorted [WIN];
    logic [PCT_W-1:0] v;
    int i, j;
    for (i = 0; i < WIN; i++) sorted[i] = window_pct[i];
    for (i = 1; i < WIN; i++) begin
      v = sorted[i];
      j = i - 1;
      while (j >= 0 && sorted[j] > v) begin
        sorted[j + 1] = sorted[j];
        j--;
      end
      sorted[j + 1] = v;
    end
    return int'(sorted[MID]);
  endfunction

  // Hold the stored level against small moves, confirm large ones
  function automatic int hold_level(int m);
    int shown;
    shown = m;
    if (held_level == 0) held_level = m;
    if (m >= held_level) begin
      if (m >= held_level + 20) begin
        up_hits = (up_hits + 1) % 4;
        if (up_hits >= 2) begin
          up_hits    = 0;
          held_level = m;
        end else begin
          shown = held_level;
        end
      end else begin
        up_hits = 0;
        shown   = held_level;
      end
    end else if (m + 10 <= held_level) begin
      down_hits = (down_hits + 1) % 4;
      if (down_hits >= 3) begin
        down_hits  = 0;
        held_level = m;
      end else begin
        shown = held_level;
      end
    end else if (m + 5 > held_level) begin
      down_hits  = 0;
      held_level = m;
    end else begin
      down_hits = 0;
    end
    return shown;
  endfunction

  // Advance the window by one accepted word and work out its level word
  function automatic level_word_t predict_level(logic [ADC_W-1:0] code);
    level_word_t w;
    int lvl;
    logic [PCT_W-1:0] pct;
    pct = percent_of(code, chan_sel);
    if (window_fill < WIN - 1) begin
      window_pct[window_fill] = pct;
      window_fill++;
      lvl    = int'(pct);
      w.done = 1'b0;
    end else begin
      window_pct[WIN - 1] = pct;
      window_fill = 0;
      lvl    = hold_level(window_median());
      w.done = 1'b1;
    end
    if (lvl < 10) lvl = 10;
    w.pct = lvl[PCT_W-1:0];
    return w;
  endfunction

  function automatic int draw_gap();
    return no_gaps ? 0 : int'($urandom_range(0, 10));
  endfunction

  // Converter word that lands near a given percent on the current scaling
  function automatic logic [ADC_W-1:0] code_near(int lvl);
    int base;
    if (chan_sel == BATT_CHANNEL) base = 336 + lvl * 80 / 100;
    else base = 1462 + lvl * 352 / 100;
    base += int'($urandom_range(0, 6)) - 3;
    return base[ADC_W-1:0];
  endfunction

  // Offer one sample word, wait for it to be taken, log what it should give
  task automatic send_word(logic [ADC_W-1:0] code, logic typed,
                           logic [PCT_W-1:0] pct, logic done);
    level_word_t w;
    int gap;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk);
      adc_if.valid = 1'b0;
    end
    @(negedge clk);
    adc_if.valid    = 1'b1;
    adc_if.adc_code = code;
    do @(posedge clk); while (!adc_if.ready);
    w = predict_level(code);
    if (typed) begin
      w.pct  = pct;
      w.done = done;
    end
    pending_levels.push_back(w);
  endtask

  // Well-formed windows around a wandering level, with noise mixed in
  task automatic send_random_word();
    logic [ADC_W-1:0] code;
    if (window_fill == 0) begin
      case ($urandom_range(0, 11))
        0, 1:    target_level = $urandom_range(0, 100);
        2, 3:    target_level += $urandom_range(20, 40);
        4:       target_level -= $urandom_range(1, 4);
        5:       target_level -= $urandom_range(5, 9);
        6, 7:    target_level -= $urandom_range(10, 30);
        8:       target_level += int'($urandom_range(0, 4)) - 2;
        default: ;
      endcase
      if (target_level < 0) target_level = 0;
      if (target_level > 100) target_level = 100;
      noisy_window = ($urandom_range(0, 9) == 0);
    end
    if (noisy_window || $urandom_range(0, 9) == 0) code = ADC_W'($urandom);
    else code = code_near(target_level);
    send_word(code, 1'b0, '0, 1'b0);
  endtask

  task automatic drain_levels();
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // APB write: setup then access, lands at the edge with pready high
  task automatic write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    chan_sel = data[CHAN_W-1:0];
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Drop the sample word, let the block empty, then switch channel
  task automatic set_channel(logic [CHAN_W-1:0] chan);
    @(negedge clk);
    adc_if.valid = 1'b0;
    drain_levels();
    write_reg(ADDR_ADC_CHANNEL, {{(CFG_DW - CHAN_W){1'b0}}, chan});
  endtask

  // Receiver: stall for a drawn number of cycles before each level word
  initial begin
    level_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      repeat (draw_gap()) begin
        @(negedge clk);
        level_if.ready = 1'b0;
      end
      @(negedge clk);
      level_if.ready = 1'b1;
      do @(posedge clk); while (!level_if.valid);
    end
  end

  // Compare each level word with the oldest pending one
  always @(posedge clk) begin : level_check
    level_word_t want;
    if (!rst && level_if.valid && level_if.ready) begin
      if (pending_levels.size() == 0) begin
        level_errors++;
        if (level_errors <= MAX_REPORTS)
          $display("unexpected level word: level_percent=%0d window_done=%0d",
                   level_if.level_percent, level_if.window_done);
      end else begin
        want = pending_levels.pop_front();
        if (level_if.level_percent !== want.pct || level_if.window_done !== want.done) begin
          level_errors++;
          if (level_errors <= MAX_REPORTS)
            $display("level word mismatch: level_percent exp %0d got %0d, window_done exp %0d got %0d",
                     want.pct, level_if.level_percent, want.done, level_if.window_done);
        end
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int row, sent, phase, phase_len;
    logic [CHAN_W-1:0] pick;
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    adc_if.valid    = 1'b0;
    adc_if.adc_code = '0;
    cycle_count     = 0;
    level_errors    = 0;
    no_gaps         = 1'b0;
    target_level    = 50;
    noisy_window    = 1'b0;
    window_fill     = 0;
    held_level      = 0;
    up_hits         = 0;
    down_hits       = 0;
    chan_sel        = GPIO_CHAN_LOW;
    for (int i = 0; i < WIN; i++) window_pct[i] = '0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed words, switching channel when the row asks for another
    for (row = 0; row < DIRECTED_N; row++) begin
      if (DIRECTED_ROWS[row].chan != chan_sel) set_channel(DIRECTED_ROWS[row].chan);
      send_word(DIRECTED_ROWS[row].code, DIRECTED_ROWS[row].typed,
                DIRECTED_ROWS[row].pct, DIRECTED_ROWS[row].done);
    end

    // Random phases, each on its own channel setting
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_WORDS) begin
      case (phase)
        0:       pick = GPIO_CHAN_LOW;
        1:       pick = GPIO_CHAN_MAX;
        2:       pick = GPIO_CHAN_TOP;
        default: begin
          case ($urandom_range(0, 5))
            0, 1, 2: pick = BATT_CHANNEL;
            3:       pick = GPIO_CHAN_LOW;
            default: pick = CHAN_W'($urandom_range(0, 15));
          endcase
        end
      endcase
      set_channel(pick);
      no_gaps   = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(60, 200);
      for (int n = 0; n < phase_len && sent < RANDOM_WORDS; n++) begin
        send_random_word();
        sent++;
      end
      phase++;
    end

    @(negedge clk);
    adc_if.valid = 1'b0;
    drain_levels();

    if (level_errors == 0 && pending_levels.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
